// File: rtl/interval_value_map_macros.svh
// Assertion macros for the interval value map block.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INTERVAL_VALUE_MAP_MACROS_SVH
`define INTERVAL_VALUE_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define IVM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("interval_value_map: check failed");
`define IVM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("interval_value_map: check failed");
`else
`define IVM_ASSERT(lbl, cond)
`define IVM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/ivm_pkg.sv
// Shared types and constants of the interval value map.
// No dependencies; used by ivm_cell, ivm_chain, interval_value_map and the test files.
`default_nettype none
package ivm_pkg;
    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_VALUE_BITS = 8;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DEL,
        OP_INS
    } cell_op_t;

    // Summary flags that the chain reports to the controller.
    typedef struct packed {
        logic any_mid;
        logic multi_mid;
        logic has_lt;
    } chain_status_t;
endpackage
`default_nettype wire

// File: rtl/ivm_cell.sv
// One breakpoint cell of the chain: a key, a value and a valid bit.
// Depends on ivm_pkg; takes its neighbors' contents on delete and insert.
`default_nettype none
module ivm_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 8,
    parameter bit IS_FIRST   = 1'b0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ivm_pkg::cell_op_t     op,
    input  wire  [KEY_BITS-1:0]   cmp_begin,
    input  wire  [KEY_BITS-1:0]   cmp_end,
    input  wire  [KEY_BITS-1:0]   ins_key,
    input  wire  [VALUE_BITS-1:0] ins_value,
    input  wire  [VALUE_BITS-1:0] clr_value,
    input  wire                   prev_valid,
    input  wire  [KEY_BITS-1:0]   prev_key,
    input  wire  [VALUE_BITS-1:0] prev_value,
    input  wire                   prev_lt,
    input  wire                   next_valid,
    input  wire  [KEY_BITS-1:0]   next_key,
    input  wire  [VALUE_BITS-1:0] next_value,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  lt,
    output logic                  le_begin,
    output logic                  le_end
);
    import ivm_pkg::*;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    assign valid    = valid_reg;
    assign key      = key_reg;
    assign value    = value_reg;
    assign lt       = valid_reg && (key_reg < cmp_begin);
    assign le_begin = valid_reg && (key_reg <= cmp_begin);
    assign le_end   = valid_reg && (key_reg <= cmp_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= IS_FIRST;
            key_reg   <= '0;
            value_reg <= '0;
        end
        else
        begin
            unique case (op)
                OP_CLEAR:
                begin
                    valid_reg <= IS_FIRST;
                    key_reg   <= '0;
                    value_reg <= clr_value;
                end
                OP_DEL:
                begin
                    // Every cell from the first one at or above the begin key
                    // moves one place toward the head.
                    if (!lt)
                    begin
                        valid_reg <= next_valid;
                        key_reg   <= next_key;
                        value_reg <= next_value;
                    end
                end
                OP_INS:
                begin
                    if (!lt)
                    begin
                        if (IS_FIRST || prev_lt)
                        begin
                            valid_reg <= 1'b1;
                            key_reg   <= ins_key;
                            value_reg <= ins_value;
                        end
                        else
                        begin
                            valid_reg <= prev_valid;
                            key_reg   <= prev_key;
                            value_reg <= prev_value;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/ivm_chain.sv
// Row of breakpoint cells with the selection logic that reads values out of it.
// Depends on ivm_pkg, ivm_cell and interval_value_map_macros.svh.
`default_nettype none
module ivm_chain #(
    parameter int ENTRIES    = 32,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 8
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  ivm_pkg::cell_op_t       op,
    input  wire  [KEY_BITS-1:0]     key_begin,
    input  wire  [KEY_BITS-1:0]     key_end,
    input  wire  [KEY_BITS-1:0]     ins_key,
    input  wire  [VALUE_BITS-1:0]   ins_value,
    input  wire  [VALUE_BITS-1:0]   clr_value,
    output logic [VALUE_BITS-1:0]   lookup_value,
    output logic [VALUE_BITS-1:0]   end_value,
    output logic [VALUE_BITS-1:0]   prev_value,
    output ivm_pkg::chain_status_t  sts
);
    import ivm_pkg::*;

    logic [ENTRIES:0]      valid_v;
    logic [ENTRIES:0]      lt_v;
    logic [ENTRIES:0]      leb_v;
    logic [ENTRIES:0]      lee_v;
    logic [ENTRIES:0]      mid_v;
    logic [KEY_BITS-1:0]   key_a   [ENTRIES+1];
    logic [VALUE_BITS-1:0] value_a [ENTRIES+1];

    // Past the tail the chain reads as one empty cell.
    assign valid_v[ENTRIES] = 1'b0;
    assign lt_v[ENTRIES]    = 1'b0;
    assign leb_v[ENTRIES]   = 1'b0;
    assign lee_v[ENTRIES]   = 1'b0;
    assign mid_v[ENTRIES]   = 1'b0;
    assign key_a[ENTRIES]   = '0;
    assign value_a[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        localparam int P = (i == 0) ? ENTRIES : i - 1;
        ivm_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .IS_FIRST   (i == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .cmp_begin  (key_begin),
            .cmp_end    (key_end),
            .ins_key    (ins_key),
            .ins_value  (ins_value),
            .clr_value  (clr_value),
            .prev_valid (valid_v[P]),
            .prev_key   (key_a[P]),
            .prev_value (value_a[P]),
            .prev_lt    (lt_v[P]),
            .next_valid (valid_v[i+1]),
            .next_key   (key_a[i+1]),
            .next_value (value_a[i+1]),
            .valid      (valid_v[i]),
            .key        (key_a[i]),
            .value      (value_a[i]),
            .lt         (lt_v[i]),
            .le_begin   (leb_v[i]),
            .le_end     (lee_v[i])
        );
        assign mid_v[i] = valid_v[i] && !lt_v[i] && lee_v[i];
    end

    // The flags form a prefix of the sorted row, so the last set cell is the
    // one whose right neighbor is clear.
    always_comb
    begin
        lookup_value  = '0;
        end_value     = '0;
        prev_value    = '0;
        sts.any_mid   = 1'b0;
        sts.multi_mid = 1'b0;
        sts.has_lt    = lt_v[0];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (leb_v[i] && !leb_v[i+1])
                lookup_value = lookup_value | value_a[i];
            if (lee_v[i] && !lee_v[i+1])
                end_value = end_value | value_a[i];
            if (lt_v[i] && !lt_v[i+1])
                prev_value = prev_value | value_a[i];
            sts.any_mid   = sts.any_mid | mid_v[i];
            sts.multi_mid = sts.multi_mid | (mid_v[i] && mid_v[i+1]);
        end
    end

`include "interval_value_map_macros.svh"
    // An insert must never push a live breakpoint off the tail.
    `IVM_ASSERT(a_ins_room, (op != OP_INS) || !valid_v[ENTRIES-1])
endmodule
`default_nettype wire

// File: rtl/interval_value_map.sv
// Interval value map: a sorted row of breakpoint cells under a small sequencer.
// Depends on ivm_pkg, ivm_chain and interval_value_map_macros.svh.
//
// Use: input words arrive on s_tvalid/s_tready; s_tuser selects assign (0) or
// lookup (1), s_tdata carries key_begin, key_end and new_value. Each input word
// gives exactly one output word on m_tvalid/m_tready: m_tdata holds read_value
// and entries_used, m_tuser holds the status (1 = assign dropped, table full).
// A lookup reads its value in the evaluate step and then loads the output
// register. An assign deletes the breakpoints that fall inside [key_begin,
// key_end], one such breakpoint per cycle, and then inserts up to two, each a
// single shift of the cell row. Empty intervals and full-table assigns finish
// like a lookup. The sequencer returns to idle as the result is loaded, and
// the next word is taken from idle. One word is in work at a time; a new word
// is accepted once the previous result sits in the output register, even
// while that result is still stalled by the receiver. A stalled receiver
// holds the sequencer in its final step until the output register frees up.
// The cfg channel writes init_value and clears the table to one breakpoint
// (key 0, init_value) in the same cycle. Reset leaves the same table with
// init_value 0; no clearing pass is needed.
`default_nettype none
module interval_value_map #(
    parameter int  ENTRIES    = ivm_pkg::DEF_ENTRIES,
    parameter int  KEY_BITS   = ivm_pkg::DEF_KEY_BITS,
    parameter int  VALUE_BITS = ivm_pkg::DEF_VALUE_BITS,
    localparam int CNT_W      = $clog2(ENTRIES + 1),
    localparam int IN_W       = ((2 * KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((VALUE_BITS + CNT_W + 7) / 8) * 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [VALUE_BITS-1:0] cfg_data,   // init_value
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [IN_W-1:0]       s_tdata,    // key_begin, key_end, new_value
    input  wire                   s_tuser,    // func
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [OUT_W-1:0]      m_tdata,    // read_value, entries_used
    output logic                  m_tuser     // status
);
    import ivm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DEL,
        S_INS_E,
        S_INS_B,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t                state_reg;
    logic                  func_reg;
    logic [KEY_BITS-1:0]   kb_reg;
    logic [KEY_BITS-1:0]   ke_reg;
    logic [VALUE_BITS-1:0] nv_reg;
    logic [VALUE_BITS-1:0] endv_reg;
    logic                  keep_b_reg;
    logic                  keep_e_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] res_rv_reg;
    logic                  res_st_reg;
    logic [VALUE_BITS-1:0] out_rv_reg;
    logic                  out_st_reg;
    logic [CNT_W-1:0]      out_cnt_reg;
    logic                  m_valid_reg;

    cell_op_t              op;
    logic [KEY_BITS-1:0]   ins_key;
    logic [VALUE_BITS-1:0] ins_value;
    logic [VALUE_BITS-1:0] lookup_value;
    logic [VALUE_BITS-1:0] end_value;
    logic [VALUE_BITS-1:0] prev_value;
    chain_status_t         sts;
    logic                  cfg_fire;
    logic                  s_fire;
    logic                  keep_b;
    logic                  keep_e;
    logic                  ins_two;
    logic                  ins_one;
    logic                  full;
    logic                  out_free;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_rv_reg});
    assign m_tuser  = out_st_reg;

    // The begin breakpoint is redundant when the one before it already holds
    // the new value; the end breakpoint when it restores the new value.
    always_comb
    begin
        keep_b  = !(sts.has_lt && (prev_value == nv_reg));
        keep_e  = (end_value != nv_reg);
        ins_two = keep_b && keep_e;
        ins_one = keep_b ^ keep_e;
        full    = (ins_two && !sts.any_mid && (cnt_reg >= FULL_CNT - ONE_CNT))
               || (ins_two && sts.any_mid && !sts.multi_mid && (cnt_reg == FULL_CNT))
               || (ins_one && !sts.any_mid && (cnt_reg == FULL_CNT));
    end

    always_comb
    begin
        op        = OP_HOLD;
        ins_key   = ke_reg;
        ins_value = endv_reg;
        priority if (cfg_fire)
            op = OP_CLEAR;
        else if (state_reg == S_DEL && sts.any_mid)
            op = OP_DEL;
        else if (state_reg == S_INS_E && keep_e_reg)
            op = OP_INS;
        else if (state_reg == S_INS_B && keep_b_reg)
        begin
            op        = OP_INS;
            ins_key   = kb_reg;
            ins_value = nv_reg;
        end
    end

    ivm_chain #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .key_begin    (kb_reg),
        .key_end      (ke_reg),
        .ins_key      (ins_key),
        .ins_value    (ins_value),
        .clr_value    (cfg_data),
        .lookup_value (lookup_value),
        .end_value    (end_value),
        .prev_value   (prev_value),
        .sts          (sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= ONE_CNT;
            m_valid_reg <= 1'b0;
            func_reg    <= FUNC_ASSIGN;
            kb_reg      <= '0;
            ke_reg      <= '0;
            nv_reg      <= '0;
            endv_reg    <= '0;
            keep_b_reg  <= 1'b0;
            keep_e_reg  <= 1'b0;
            res_rv_reg  <= '0;
            res_st_reg  <= ST_DONE;
            out_rv_reg  <= '0;
            out_st_reg  <= ST_DONE;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_fire)
                cnt_reg <= ONE_CNT;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        func_reg  <= s_tuser;
                        kb_reg    <= s_tdata[KEY_BITS-1:0];
                        ke_reg    <= s_tdata[2*KEY_BITS-1:KEY_BITS];
                        nv_reg    <= s_tdata[2*KEY_BITS+VALUE_BITS-1:2*KEY_BITS];
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    priority if (func_reg == FUNC_LOOKUP)
                    begin
                        res_rv_reg <= lookup_value;
                        res_st_reg <= ST_DONE;
                        state_reg  <= S_DONE;
                    end
                    else if (!(kb_reg < ke_reg))
                    begin
                        res_rv_reg <= '0;
                        res_st_reg <= ST_DONE;
                        state_reg  <= S_DONE;
                    end
                    else if (full)
                    begin
                        res_rv_reg <= '0;
                        res_st_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        res_rv_reg <= '0;
                        res_st_reg <= ST_DONE;
                        keep_b_reg <= keep_b;
                        keep_e_reg <= keep_e;
                        endv_reg   <= end_value;
                        state_reg  <= S_DEL;
                    end
                end
                S_DEL:
                begin
                    if (sts.any_mid)
                        cnt_reg <= cnt_reg - ONE_CNT;
                    else
                        state_reg <= S_INS_E;
                end
                S_INS_E:
                begin
                    if (keep_e_reg)
                        cnt_reg <= cnt_reg + ONE_CNT;
                    state_reg <= S_INS_B;
                end
                S_INS_B:
                begin
                    if (keep_b_reg)
                        cnt_reg <= cnt_reg + ONE_CNT;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_rv_reg  <= res_rv_reg;
                        out_st_reg  <= res_st_reg;
                        out_cnt_reg <= cnt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "interval_value_map_macros.svh"
    // Between words the table always holds at least the key-zero breakpoint.
    `IVM_ASSERT(a_cnt_range,
        (state_reg != S_IDLE) || ((cnt_reg != '0) && (cnt_reg <= FULL_CNT)))
    // A dropped assign leaves the breakpoint count untouched.
    `IVM_ASSERT_NEXT(a_full_keeps,
        (state_reg == S_EVAL) && (func_reg == FUNC_ASSIGN) && (kb_reg < ke_reg) && full,
        cnt_reg == $past(cnt_reg))
    // Finishing a word always lands its result in the output register.
    `IVM_ASSERT_NEXT(a_done_out, (state_reg == S_DONE) && out_free,
        m_valid_reg && (state_reg == S_IDLE))
endmodule
`default_nettype wire

// File: test/interval_value_map_checker.sv
// Checker for the interval value map: watches the input, output and config channels,
// predicts each output word from its own breakpoint table and compares field by field.
// Depends on ivm_pkg for the function and status codes.
module interval_value_map_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [7:0]  cfg_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [39:0] s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [15:0] m_tdata,
    input  wire         m_tuser,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          full_seen
);
    import ivm_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [7:0] read_value;
        logic       status;
        logic [5:0] entries_used;
    } map_result_t;

    logic [15:0] brk_key [DEPTH];
    logic [7:0]  brk_val [DEPTH];
    int          brk_count;
    logic [7:0]  base_value;
    map_result_t expected_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic logic [7:0] value_at(input logic [15:0] k);
        logic [7:0] v;
        v = brk_val[0];
        for (int i = 1; i < brk_count; i++)
        begin
            if (brk_key[i] <= k)
                v = brk_val[i];
            else
                break;
        end
        return v;
    endfunction

    // Rebuilds the table in canonical form; returns 0 when it would overflow.
    function automatic bit assign_range(input logic [15:0] kb, input logic [15:0] ke,
                                        input logic [7:0] v);
        logic [15:0] nk [$];
        logic [7:0]  nv [$];
        logic [7:0]  end_val;
        end_val = value_at(ke);
        for (int i = 0; i < brk_count; i++)
        begin
            if (brk_key[i] < kb && (nv.size() == 0 || nv[$] != brk_val[i]))
            begin
                nk.push_back(brk_key[i]);
                nv.push_back(brk_val[i]);
            end
        end
        if (nv.size() == 0 || nv[$] != v)
        begin
            nk.push_back(kb);
            nv.push_back(v);
        end
        if (nv[$] != end_val)
        begin
            nk.push_back(ke);
            nv.push_back(end_val);
        end
        for (int i = 0; i < brk_count; i++)
        begin
            if (brk_key[i] > ke && nv[$] != brk_val[i])
            begin
                nk.push_back(brk_key[i]);
                nv.push_back(brk_val[i]);
            end
        end
        if (nk.size() > DEPTH)
            return 0;
        foreach (nk[i])
        begin
            brk_key[i] = nk[i];
            brk_val[i] = nv[i];
        end
        brk_count = nk.size();
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_result_t r;
        map_result_t got;
        if (!rst_n)
        begin
            base_value = 8'd0;
            brk_key[0] = 16'd0;
            brk_val[0] = 8'd0;
            brk_count = 1;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            full_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.read_value = m_tdata[7:0];
                got.entries_used = m_tdata[13:8];
                got.status = m_tuser;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("unexpected output word at %0t", $time);
                    fail_count++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (got.read_value != r.read_value)
                        report_mismatch("read_value", got.read_value, r.read_value);
                    if (got.status != r.status)
                        report_mismatch("status", got.status, r.status);
                    if (got.entries_used != r.entries_used)
                        report_mismatch("entries_used", got.entries_used, r.entries_used);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                base_value = cfg_data;
                brk_key[0] = 16'd0;
                brk_val[0] = cfg_data;
                brk_count = 1;
            end
            if (s_tvalid && s_tready)
            begin
                r = '0;
                r.status = ST_DONE;
                if (s_tuser == FUNC_LOOKUP)
                    r.read_value = value_at(s_tdata[15:0]);
                else if (s_tdata[15:0] < s_tdata[31:16])
                begin
                    if (!assign_range(s_tdata[15:0], s_tdata[31:16], s_tdata[39:32]))
                    begin
                        r.status = ST_FULL;
                        full_seen++;
                    end
                end
                r.entries_used = brk_count[5:0];
                expected_results.push_back(r);
            end
            pending = expected_results.size();
        end
    end
endmodule

// File: test/interval_value_map_tb.sv
// Testbench top for the interval value map: clock, reset, stimulus and verdict.
// Depends on ivm_pkg, interval_value_map and interval_value_map_checker.
module interval_value_map_tb;
    import ivm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          full_seen;
    int          words_sent;
    bit          hold_off;
    bit          stall_free;
    logic [15:0] cluster_base;

    interval_value_map dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    interval_value_map_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .full_seen(full_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: its own stall pattern, quiet stretches, and one long hold-off.
    initial
    begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_free || (phase % 64) < 16)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 9) < 6);
        end
    end

    task automatic send_word(input logic func, input logic [15:0] kb, input logic [15:0] ke,
                             input logic [7:0] v);
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {v, ke, kb};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // Drops valid between bursts; a word stays valid across back-to-back sends.
    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_and_write(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        int pick;
        logic [15:0] a;
        logic [15:0] b;
        pick = $urandom_range(0, 9);
        a = 16'(cluster_base + $urandom_range(0, 300));
        b = 16'(a + $urandom_range(1, 40));
        if (pick < 4)
            send_word(FUNC_ASSIGN, a, b, 8'($urandom_range(0, 3)));
        else if (pick < 7)
            send_word(FUNC_LOOKUP, 16'(cluster_base + $urandom_range(0, 350)),
                      16'($urandom), 8'($urandom));
        else if (pick < 8)
            send_word(FUNC_ASSIGN, 16'($urandom), 16'($urandom), 8'($urandom));
        else
            send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                      8'($urandom));
        maybe_gap();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_ASSIGN;
        hold_off = 1'b0;
        stall_free = 1'b0;
        words_sent = 0;
        cluster_base = 16'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, empty intervals, both operations.
        send_word(FUNC_LOOKUP, 16'd0, 16'hFFFF, 8'hFF);
        send_word(FUNC_LOOKUP, 16'hFFFF, 16'd0, 8'd0);
        send_word(FUNC_ASSIGN, 16'd5, 16'd5, 8'hAA);
        send_word(FUNC_ASSIGN, 16'hFFFF, 16'd0, 8'hAA);
        send_word(FUNC_ASSIGN, 16'd0, 16'hFFFF, 8'hFF);
        send_word(FUNC_LOOKUP, 16'hFFFE, 16'd0, 8'd0);
        send_word(FUNC_LOOKUP, 16'hFFFF, 16'd0, 8'd0);
        send_word(FUNC_ASSIGN, 16'd100, 16'd200, 8'h00);
        send_word(FUNC_ASSIGN, 16'd150, 16'd160, 8'hFF);
        send_word(FUNC_ASSIGN, 16'd50, 16'd300, 8'h55);
        send_word(FUNC_LOOKUP, 16'd49, 16'd0, 8'd0);
        send_word(FUNC_LOOKUP, 16'd50, 16'd0, 8'd0);
        send_word(FUNC_LOOKUP, 16'd300, 16'd0, 8'd0);
        send_word(FUNC_ASSIGN, 16'hFFFE, 16'hFFFF, 8'h01);
        send_word(FUNC_ASSIGN, 16'd0, 16'd1, 8'h02);
        // Fill toward the table limit with alternating values so the full flag fires.
        for (int i = 0; i < 20; i++)
            send_word(FUNC_ASSIGN, 16'd1000 + 16'(i * 4), 16'd1002 + 16'(i * 4), 8'(i[0]));

        drain_and_write(8'hFF);
        // Long receiver hold-off while words keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                random_word();
        join

        for (int round = 0; round < 4; round++)
        begin
            stall_free = (round == 2);
            cluster_base = 16'($urandom_range(0, 65000));
            for (int i = 0; i < 115; i++)
                random_word();
            drain_and_write(round == 0 ? 8'h00 : 8'($urandom));
        end
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        $display("Sent %0d words, checked %0d results, %0d table-full drops, five init values.",
                 words_sent, results_seen, full_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/ivm_pkg.sv
rtl/ivm_cell.sv
rtl/ivm_chain.sv
rtl/interval_value_map.sv
test/interval_value_map_checker.sv
test/interval_value_map_tb.sv
